[design/operation_queue_with_alu_unit_defines.svh]
// Assertion macros used by the checker of the operation queue.
`ifndef OPERATION_QUEUE_WITH_ALU_UNIT_DEFINES_SVH
`define OPERATION_QUEUE_WITH_ALU_UNIT_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define OQA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oqa check failed");

// Next-cycle implication, masked while reset is asserted.
`define OQA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oqa check failed");

// Next-cycle implication, checked through reset as well.
`define OQA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("oqa check failed");

`endif

[design/oqa_pkg.sv]
package oqa_pkg;

    localparam int DATA_W    = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;
    localparam int DIV_STEPS = 32;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    localparam logic ACC_PUSH = 1'b0;
    localparam logic ACC_POP  = 1'b1;

    typedef struct packed {
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [OP_W-1:0]   op;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic                exec;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill;
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
        logic [OP_W-1:0]     op;
    } t_cmd;

endpackage

[design/oqa_req_if.sv]
interface oqa_req_if;
    logic                                valid;
    logic                                ready;
    logic                                access;
    logic signed [oqa_pkg::DATA_W-1:0]   operand_a;
    logic signed [oqa_pkg::DATA_W-1:0]   operand_b;
    logic [oqa_pkg::OP_W-1:0]            opcode;

    modport source (output valid, access, operand_a, operand_b, opcode, input ready);
    modport sink   (input valid, access, operand_a, operand_b, opcode, output ready);
endinterface

[design/oqa_rsp_if.sv]
interface oqa_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [oqa_pkg::DATA_W-1:0]   result;
    logic                                result_valid;
    logic [oqa_pkg::STATUS_W-1:0]        status;
    logic [oqa_pkg::FILL_W-1:0]          fill_level;

    modport source (output valid, result, result_valid, status, fill_level, input ready);
    modport sink   (input valid, result, result_valid, status, fill_level, output ready);
endinterface

[design/oqa_ram.sv]
module oqa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/oqa_front.sv]
module oqa_front #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    oqa_req_if.sink                         i_req,
    output logic                            o_ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0]  o_ram_waddr,
    output oqa_pkg::t_entry                 o_ram_wdata,
    output logic                            o_ram_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0]  o_ram_raddr,
    input  oqa_pkg::t_entry                 i_ram_rdata,
    output logic                            o_cmd_valid,
    input  logic                            i_cmd_ready,
    output oqa_pkg::t_cmd                   o_cmd
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW+4:0] fill_ext;

    logic                          r_stg_valid;
    logic                          r_stg_exec;
    logic [oqa_pkg::STATUS_W-1:0]  r_stg_status;
    logic [oqa_pkg::FILL_W-1:0]    r_stg_fill;

    logic accept;
    logic is_full;
    logic is_empty;
    logic push_ok;
    logic pop_ok;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rp_inc;

    assign i_req.ready = !r_stg_valid || i_cmd_ready;
    assign accept      = i_req.valid && i_req.ready;
    assign is_full     = (r_count == CW'(QUEUE_DEPTH));
    assign is_empty    = (r_count == '0);
    assign push_ok     = accept && (i_req.access == oqa_pkg::ACC_PUSH) && !is_full;
    assign pop_ok      = accept && (i_req.access == oqa_pkg::ACC_POP) && !is_empty;

    assign wp_inc = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
    assign rp_inc = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);

    always_comb begin
        n_count = r_count;
        if (push_ok) begin
            n_count = CW'(r_count + 1'b1);
        end else if (pop_ok) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    // fill level shows the low five bits of the count after this access
    assign fill_ext = {5'b0, n_count};

    assign o_ram_we          = push_ok;
    assign o_ram_waddr       = r_wp;
    assign o_ram_wdata.a     = i_req.operand_a;
    assign o_ram_wdata.b     = i_req.operand_b;
    assign o_ram_wdata.op    = i_req.opcode;
    assign o_ram_re          = pop_ok;
    assign o_ram_raddr       = r_rp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_rp        <= '0;
            r_count     <= '0;
            r_stg_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wp <= wp_inc;
            end
            if (pop_ok) begin
                r_rp <= rp_inc;
            end
            if (accept) begin
                r_stg_valid <= 1'b1;
            end else if (i_cmd_ready) begin
                r_stg_valid <= 1'b0;
            end
        end
    end

    // stage payload, classified at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stg_exec <= pop_ok;
            r_stg_fill <= fill_ext[4:0];
            if (i_req.access == oqa_pkg::ACC_PUSH) begin
                r_stg_status <= is_full ? oqa_pkg::ST_FULL : oqa_pkg::ST_OK;
            end else begin
                r_stg_status <= is_empty ? oqa_pkg::ST_EMPTY : oqa_pkg::ST_OK;
            end
        end
    end

    // operands arrive from the RAM's read register, in the cycle after the read
    always_comb begin
        o_cmd.exec   = r_stg_exec;
        o_cmd.status = r_stg_status;
        o_cmd.fill   = r_stg_fill;
        o_cmd.a      = i_ram_rdata.a;
        o_cmd.b      = i_ram_rdata.b;
        o_cmd.op     = i_ram_rdata.op;
    end

    assign o_cmd_valid = r_stg_valid;

endmodule

[design/oqa_cmd_fifo.sv]
module oqa_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  oqa_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output oqa_pkg::t_cmd  o_cmd
);

    oqa_pkg::t_cmd r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          push;
    logic          pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= !r_wr;
            end
            if (pop) begin
                r_rd <= !r_rd;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[design/oqa_back.sv]
module oqa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  oqa_pkg::t_cmd  i_cmd,
    oqa_rsp_if.source      o_rsp
);

    localparam int SW = $clog2(oqa_pkg::DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state                         r_state;
    logic [SW-1:0]                  r_step;
    logic [oqa_pkg::DATA_W-1:0]     r_rem;
    logic [oqa_pkg::DATA_W-1:0]     r_quo;
    logic [oqa_pkg::DATA_W-1:0]     r_dvs;
    logic                           r_neg;
    logic [oqa_pkg::FILL_W-1:0]     r_fill;

    logic                           r_out_valid;
    logic [oqa_pkg::DATA_W-1:0]     r_result;
    logic                           r_rvalid;
    logic [oqa_pkg::STATUS_W-1:0]   r_status;
    logic [oqa_pkg::FILL_W-1:0]     r_fill_out;

    logic                           out_free;
    logic                           take;
    logic                           start_div;
    logic                           load_out;
    logic [oqa_pkg::DATA_W:0]       trial;
    logic [oqa_pkg::DATA_W:0]       diff;
    logic                           ge;
    logic [oqa_pkg::DATA_W-1:0]     mag_a;
    logic [oqa_pkg::DATA_W-1:0]     mag_b;
    logic [oqa_pkg::DATA_W-1:0]     alu_res;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign o_cmd_ready = (r_state == S_IDLE) && out_free;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign start_div   = i_cmd.exec && (i_cmd.op == oqa_pkg::OP_DIV) && (i_cmd.b != '0);
    assign load_out    = (take && !start_div) || (r_state == S_FIN);

    assign mag_a = i_cmd.a[oqa_pkg::DATA_W-1] ? (oqa_pkg::DATA_W'(0) - i_cmd.a) : i_cmd.a;
    assign mag_b = i_cmd.b[oqa_pkg::DATA_W-1] ? (oqa_pkg::DATA_W'(0) - i_cmd.b) : i_cmd.b;

    // one restoring step per cycle
    assign trial = {r_rem, r_quo[oqa_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_comb begin
        case (i_cmd.op)
            oqa_pkg::OP_ADD: alu_res = i_cmd.a + i_cmd.b;
            oqa_pkg::OP_SUB: alu_res = i_cmd.a - i_cmd.b;
            oqa_pkg::OP_MUL: alu_res = i_cmd.a * i_cmd.b;
            default:         alu_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        if (start_div) begin
                            r_neg   <= i_cmd.a[oqa_pkg::DATA_W-1] ^ i_cmd.b[oqa_pkg::DATA_W-1];
                            r_quo   <= mag_a;
                            r_dvs   <= mag_b;
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_fill  <= i_cmd.fill;
                            r_state <= S_DIV;
                        end else begin
                            r_fill_out  <= i_cmd.fill;
                            if (!i_cmd.exec) begin
                                r_result <= '0;
                                r_rvalid <= 1'b0;
                                r_status <= i_cmd.status;
                            end else if (i_cmd.op == oqa_pkg::OP_DIV) begin
                                r_result <= '0;
                                r_rvalid <= 1'b0;
                                r_status <= oqa_pkg::ST_DIVZERO;
                            end else begin
                                r_result <= alu_res;
                                r_rvalid <= 1'b1;
                                r_status <= oqa_pkg::ST_OK;
                            end
                        end
                    end
                end
                S_DIV: begin
                    r_rem  <= ge ? diff[oqa_pkg::DATA_W-1:0] : trial[oqa_pkg::DATA_W-1:0];
                    r_quo  <= {r_quo[oqa_pkg::DATA_W-2:0], ge};
                    r_step <= SW'(r_step + 1'b1);
                    if (r_step == SW'(oqa_pkg::DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // apply the sign; INT_MIN / -1 wraps here
                    r_result    <= r_neg ? (oqa_pkg::DATA_W'(0) - r_quo) : r_quo;
                    r_rvalid    <= 1'b1;
                    r_status    <= oqa_pkg::ST_OK;
                    r_fill_out  <= r_fill;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result       = r_result;
    assign o_rsp.result_valid = r_rvalid;
    assign o_rsp.status       = r_status;
    assign o_rsp.fill_level   = r_fill_out;

endmodule

[design/operation_queue_with_alu_unit.sv]
// Path: front stage register, command FIFO, back output register; a divide with
// a nonzero divisor adds setup, 32 radix-2 steps in S_DIV and sign in S_FIN.
// Throughput: one item per cycle into the front while the FIFO has room; the
// back retires one item per cycle unless o_rsp stalls; divides hold it longer.
// Reset: synchronous active-low i_rst_n clears pointers, count and all valid
// state; the request RAM is not cleared.
module operation_queue_with_alu_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oqa_req_if.sink    i_req,
    oqa_rsp_if.source  o_rsp
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic             ram_we;
    logic [PW-1:0]    ram_waddr;
    oqa_pkg::t_entry  ram_wdata;
    logic             ram_re;
    logic [PW-1:0]    ram_raddr;
    oqa_pkg::t_entry  ram_rdata;

    logic             fr_valid;
    logic             fr_ready;
    oqa_pkg::t_cmd    fr_cmd;
    logic             bk_valid;
    logic             bk_ready;
    oqa_pkg::t_cmd    bk_cmd;

    oqa_ram #(
        .WIDTH (oqa_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    oqa_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_cmd_valid (fr_valid),
        .i_cmd_ready (fr_ready),
        .o_cmd       (fr_cmd)
    );

    oqa_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_cmd   (fr_cmd),
        .o_valid (bk_valid),
        .i_ready (bk_ready),
        .o_cmd   (bk_cmd)
    );

    oqa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (bk_valid),
        .o_cmd_ready (bk_ready),
        .i_cmd       (bk_cmd),
        .o_rsp       (o_rsp)
    );

endmodule

[design/oqa_checker.sv]
`include "operation_queue_with_alu_unit_defines.svh"

module oqa_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [oqa_pkg::DATA_W-1:0]    i_result,
    input logic                          i_result_valid,
    input logic [oqa_pkg::STATUS_W-1:0]  i_status
);

    // a stalled item keeps its payload
    `OQA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_result) && $stable(i_status))

    // a computed value always comes with an ok status
    `OQA_ASSERT_NOW(a_valid_ok, i_clk, i_rst_n, i_rsp_valid && i_result_valid, i_status == oqa_pkg::ST_OK)

    // rejected, empty and divide-by-zero items carry a zero result
    `OQA_ASSERT_NOW(a_err_zero, i_clk, i_rst_n, i_rsp_valid && (i_status != oqa_pkg::ST_OK), i_result == '0 && !i_result_valid)

    // reset drops any pending result
    `OQA_ASSERT_NEXT_ALWAYS(a_rst_idle, i_clk, !i_rst_n, !i_rsp_valid)

endmodule

bind operation_queue_with_alu_unit oqa_checker u_oqa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_result       (o_rsp.result),
    .i_result_valid (o_rsp.result_valid),
    .i_status       (o_rsp.status)
);
